### hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property that must hold during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/sha512f_pkg.sv
// Types, constants and round functions for the fixed-size SHA-512 unit.
// No dependencies.
package sha512f_pkg;

    localparam int NumRounds = 80;

    typedef struct packed {
        logic [63:0] msg_word0;
        logic [63:0] msg_word1;
        logic [63:0] msg_word2;
        logic [63:0] msg_word3;
    } msg_t;

    typedef struct packed {
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
        logic [63:0] digest_word4;
        logic [63:0] digest_word5;
        logic [63:0] digest_word6;
        logic [63:0] digest_word7;
    } digest_t;

    typedef logic [7:0][63:0] vars_t;
    typedef logic [15:0][63:0] sched_t;

    localparam logic [63:0] PadWord = 64'h8000000000000000;
    localparam logic [63:0] LenWord = 64'd256;

    localparam vars_t Iv = {
        64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
        64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
        64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
        64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908
    };

    localparam logic [79:0][63:0] RoundK = {
        64'h6C44198C4A475817, 64'h5FCB6FAB3AD6FAEC, 64'h597F299CFC657E2A, 64'h4CC5D4BECB3E42B6,
        64'h431D67C49C100D4C, 64'h3C9EBE0A15C9BEBC, 64'h32CAAB7B40C72493, 64'h28DB77F523047D84,
        64'h1B710B35131C471B, 64'h113F9804BEF90DAE, 64'h0A637DC5A2C898A6, 64'h06F067AA72176FBA,
        64'hF57D4F7FEE6ED178, 64'hEADA7DD6CDE0EB1E, 64'hD186B8C721C0C207, 64'hCA273ECEEA26619C,
        64'hC67178F2E372532B, 64'hBEF9A3F7B2C67915, 64'hA4506CEBDE82BDE9, 64'h90BEFFFA23631E28,
        64'h8CC702081A6439EC, 64'h84C87814A1F0AB72, 64'h78A5636F43172F60, 64'h748F82EE5DEFB2FC,
        64'h682E6FF3D6B2B8A3, 64'h5B9CCA4F7763E373, 64'h4ED8AA4AE3418ACB, 64'h391C0CB3C5C95A63,
        64'h34B0BCB5E19B48A8, 64'h2748774CDF8EEB99, 64'h1E376C085141AB53, 64'h19A4C116B8D2D0C8,
        64'h106AA07032BBD1B8, 64'hF40E35855771202A, 64'hD69906245565A910, 64'hD192E819D6EF5218,
        64'hC76C51A30654BE30, 64'hC24B8B70D0F89791, 64'hA81A664BBC423001, 64'hA2BFE8A14CF10364,
        64'h92722C851482353B, 64'h81C2C92E47EDAEE6, 64'h766A0ABB3C77B2A8, 64'h650A73548BAF63DE,
        64'h53380D139D95B3DF, 64'h4D2C6DFC5AC42AED, 64'h2E1B21385C26C926, 64'h27B70A8546D22FFC,
        64'h142929670A0E6E70, 64'h06CA6351E003826F, 64'hD5A79147930AA725, 64'hC6E00BF33DA88FC2,
        64'hBF597FC7BEEF0EE4, 64'hB00327C898FB213F, 64'hA831C66D2DB43210, 64'h983E5152EE66DFAB,
        64'h76F988DA831153B5, 64'h5CB0A9DCBD41FBD4, 64'h4A7484AA6EA6E483, 64'h2DE92C6F592B0275,
        64'h240CA1CC77AC9C65, 64'h0FC19DC68B8CD5B5, 64'hEFBE4786384F25E3, 64'hE49B69C19EF14AD2,
        64'hC19BF174CF692694, 64'h9BDC06A725C71235, 64'h80DEB1FE3B1696B1, 64'h72BE5D74F27B896F,
        64'h550C7DC3D5FFB4E2, 64'h243185BE4EE4B28C, 64'h12835B0145706FBE, 64'hD807AA98A3030242,
        64'hAB1C5ED5DA6D8118, 64'h923F82A4AF194F9B, 64'h59F111F1B605D019, 64'h3956C25BF348B538,
        64'hE9B5DBA58189DBBC, 64'hB5C0FBCFEC4D3B2F, 64'h7137449123EF65CD, 64'h428A2F98D728AE22
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sig0(input logic [63:0] x);
        big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_sig1(input logic [63:0] x);
        big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_sig0(input logic [63:0] x);
        small_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sig1(input logic [63:0] x);
        small_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

endpackage

### hdl/sha512f_round.sv
// One registered SHA-512 round plus one schedule step.
// Depends on sha512f_pkg.
module sha512f_round
    import sha512f_pkg::*;
#(
    parameter int Round = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  vars_t  in_vars,
    input  sched_t in_sched,
    output logic   out_valid,
    output vars_t  out_vars,
    output sched_t out_sched
);

    logic   valid_reg;
    vars_t  vars_reg, vars_next;
    sched_t sched_reg, sched_next;
    logic [63:0] ch, mj, t1, t2, w_new;

    always_comb
    begin
        // window slot 0 holds W[Round]; append W[Round+16]
        w_new = small_sig1(in_sched[14]) + in_sched[9] + small_sig0(in_sched[1]) + in_sched[0];
        sched_next = {w_new, in_sched[15:1]};
        ch = (in_vars[4] & in_vars[5]) ^ (~in_vars[4] & in_vars[6]);
        mj = (in_vars[0] & in_vars[1]) ^ (in_vars[0] & in_vars[2]) ^ (in_vars[1] & in_vars[2]);
        t1 = in_vars[7] + big_sig1(in_vars[4]) + ch + RoundK[Round] + in_sched[0];
        t2 = big_sig0(in_vars[0]) + mj;
        vars_next = {in_vars[6], in_vars[5], in_vars[4], in_vars[3] + t1,
                     in_vars[2], in_vars[1], in_vars[0], t1 + t2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        vars_reg  <= vars_next;
        sched_reg <= sched_next;
    end

    assign out_valid = valid_reg;
    assign out_vars  = vars_reg;
    assign out_sched = sched_reg;

endmodule

### hdl/sha512_fixed_32_byte_message_unit.sv
// Top level of the fixed 32-byte SHA-512 unit: 80 round stages and a final add.
// Depends on sha512f_pkg, sha512f_round and assert_macros.svh.
//
// Usage:
//   Drive msg with the four message words and pulse start. busy is always
//   low, so an item is accepted at every edge where start is high.
//   done is high for one cycle with the digest on result; the receiver
//   must take it then, as it cannot stall the unit.
// Path: from acceptance to done an item passes the 80 round stages (each one
//   registered round with its schedule step), then the registered final IV add.
// Throughput: one item per cycle; each round stage holds its own item.
// Reset: clears the valid bits of all stages; items in flight are dropped.
//   Payload registers are not reset.
// Results leave in acceptance order.
`include "assert_macros.svh"
module sha512_fixed_32_byte_message_unit
    import sha512f_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  msg_t    msg,
    output logic    done,
    output digest_t result
);

    logic   [NumRounds:0] stg_valid;
    vars_t  stg_vars  [NumRounds+1];
    sched_t stg_sched [NumRounds+1];
    logic    done_reg;
    digest_t result_reg, result_next;

    assign busy = 1'b0;

    assign stg_valid[0] = start;
    assign stg_vars[0]  = Iv;
    assign stg_sched[0] = {LenWord, {10{64'd0}}, PadWord,
                           msg.msg_word3, msg.msg_word2, msg.msg_word1, msg.msg_word0};

    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        sha512f_round #(.Round(r)) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stg_valid[r]),
            .in_vars  (stg_vars[r]),
            .in_sched (stg_sched[r]),
            .out_valid(stg_valid[r+1]),
            .out_vars (stg_vars[r+1]),
            .out_sched(stg_sched[r+1])
        );
    end

    always_comb
    begin
        result_next.digest_word0 = Iv[0] + stg_vars[NumRounds][0];
        result_next.digest_word1 = Iv[1] + stg_vars[NumRounds][1];
        result_next.digest_word2 = Iv[2] + stg_vars[NumRounds][2];
        result_next.digest_word3 = Iv[3] + stg_vars[NumRounds][3];
        result_next.digest_word4 = Iv[4] + stg_vars[NumRounds][4];
        result_next.digest_word5 = Iv[5] + stg_vars[NumRounds][5];
        result_next.digest_word6 = Iv[6] + stg_vars[NumRounds][6];
        result_next.digest_word7 = Iv[7] + stg_vars[NumRounds][7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stg_valid[NumRounds];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_done_follows_last, clk, rst_n, stg_valid[NumRounds] |=> done, "done lost")
    `ASSERT_CLK(a_mid_valid, clk, rst_n, start |-> ##40 stg_valid[40], "item lost mid pipe")
    `ASSERT_ALWAYS(a_reset_done, clk, !rst_n |-> !done, "done during reset")

endmodule
